>>> hdl/mlpwp_pkg.sv
// Shared types, constants and the sigmoid table of the window predictor.
`timescale 1ns / 1ps

package mlpwp_pkg;

   localparam int WINDOW_TAPS_DEF  = 8;
   localparam int HIDDEN_UNITS_DEF = 3;

   localparam int SAMPLE_W   = 16;
   localparam int INDEX_W    = 5;
   localparam int PRED_W     = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HMAC,
      ST_HDRAIN,
      ST_SIG,
      ST_OTHR,
      ST_ODRAIN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_HMAC,
      OP_HTHR,
      OP_OMAC,
      OP_OTHR
   } op_type;

   // Rounded 1/(1+2^-v) in unsigned Q0.16, indexed by v in quarter steps from -8.
   localparam logic [15:0] SIGMOID_TABLE [64] = '{
      16'd255,   16'd303,   16'd360,   16'd428,   16'd508,   16'd603,   16'd716,   16'd850,
      16'd1008,  16'd1196,  16'd1417,  16'd1678,  16'd1986,  16'd2348,  16'd2774,  16'd3272,
      16'd3855,  16'd4534,  16'd5322,  16'd6233,  16'd7282,  16'd8481,  16'd9845,  16'd11384,
      16'd13107, 16'd15019, 16'd17118, 16'd19398, 16'd21845, 16'd24437, 16'd27146, 16'd29936,
      16'd32768, 16'd35600, 16'd38390, 16'd41099, 16'd43691, 16'd46138, 16'd48418, 16'd50517,
      16'd52429, 16'd54152, 16'd55691, 16'd57055, 16'd58254, 16'd59303, 16'd60214, 16'd61002,
      16'd61681, 16'd62264, 16'd62762, 16'd63188, 16'd63550, 16'd63858, 16'd64119, 16'd64340,
      16'd64528, 16'd64686, 16'd64820, 16'd64933, 16'd65028, 16'd65108, 16'd65176, 16'd65233
   };

endpackage

>>> hdl/mlp_window_predictor.sv
// Top level of the sliding-window perceptron predictor.
`timescale 1ns / 1ps

// Channel   Direction  Beat carries
// req_      in         tuser: kind; tdata: sample_value, weight_index, weight_value
// rsp_      out        tuser: window_full; tdata: prediction
//
// A sample beat is worked through in full before the next beat can be taken; the
// single shared 17x16 multiply-accumulate unit works through every hidden and output
// product in turn, one weight read from the weight RAM per cycle, pausing while the
// pipeline drains before each sigmoid and before the result. A weight-write beat is
// written straight into the weight RAM. After reset the weight RAM is cleared one
// entry a cycle through all STORE_DEPTH entries; no beat is taken then.
// A finished result waits in the output register while the next beat is accepted; the
// sequencer only holds at its end if that register is still full.

module mlp_window_predictor #(
   parameter int WINDOW_TAPS  = mlpwp_pkg::WINDOW_TAPS_DEF,
   parameter int HIDDEN_UNITS = mlpwp_pkg::HIDDEN_UNITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] sample_value, [20:16] weight_index, [36:21] weight_value, [39:37] zero
   input  logic [mlpwp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] prediction
   output logic [mlpwp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [0] window_full
   output logic                              rsp_tuser
);

   // Weight store layout: hidden weights (unit-major), output weights,
   // hidden thresholds, then the output threshold.
   localparam int OW_BASE     = HIDDEN_UNITS * WINDOW_TAPS;
   localparam int HT_BASE     = OW_BASE + HIDDEN_UNITS;
   localparam int OT_INDEX    = HT_BASE + HIDDEN_UNITS;
   localparam int STORE_DEPTH = OT_INDEX + 1;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IW          = (AW > mlpwp_pkg::INDEX_W) ? AW : mlpwp_pkg::INDEX_W;
   localparam int TW          = $clog2(WINDOW_TAPS);
   localparam int CW          = $clog2(WINDOW_TAPS + 1);
   localparam int UW          = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
   // Hidden sums stay exact in Q.28; output sums in Q.30 with headroom for every term.
   localparam int HACC_W      = 33 + $clog2(WINDOW_TAPS);
   localparam int OACC_W      = 34 + $clog2(HIDDEN_UNITS);

   mlpwp_pkg::state_type state_ff, state_in;
   mlpwp_pkg::op_type    op1_ff, op1_in;
   mlpwp_pkg::op_type    op2_ff, op2_in;

   logic [UW-1:0]                 unit_ff, unit_in;
   logic [CW-1:0]                 tap_ff, tap_in;
   logic [AW-1:0]                 hw_ptr_ff, hw_ptr_in;
   logic [AW-1:0]                 clr_ptr_ff, clr_ptr_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic signed [15:0]            taps_ff [WINDOW_TAPS];
   logic signed [15:0]            taps_in [WINDOW_TAPS];
   logic signed [16:0]            opa_ff, opa_in;
   logic signed [32:0]            prod_ff, prod_in;
   logic signed [HACC_W-1:0]      acc_h_ff, acc_h_in;
   logic signed [OACC_W-1:0]      acc_o_ff, acc_o_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [mlpwp_pkg::PRED_W-1:0]  rsp_pred_ff, rsp_pred_in;
   logic                          rsp_full_ff, rsp_full_in;

   logic                          ram_we;
   logic [AW-1:0]                 ram_waddr;
   logic [15:0]                   ram_wdata;
   logic [AW-1:0]                 ram_raddr;
   logic [15:0]                   ram_rdata;
   logic signed [15:0]            wt_s;
   logic signed [32:0]            mul_prod;

   logic                          req_kind;
   logic signed [15:0]            req_sample;
   logic [IW-1:0]                 req_index;
   logic [15:0]                   req_weight;

   logic [31:0]                   hid_sat;
   logic [5:0]                    sig_index;
   logic [15:0]                   sig_value;
   logic [31:0]                   out_sat;

   assign req_kind   = req_tuser;
   assign req_sample = req_tdata[15:0];
   assign req_index  = IW'(req_tdata[20:16]);
   assign req_weight = req_tdata[36:21];

   assign req_tready = (state_ff == mlpwp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pred_ff;
   assign rsp_tuser  = rsp_full_ff;

   mlpwp_ram #(
      .WIDTH (16),
      .DEPTH (STORE_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign wt_s = ram_rdata;

   // The one shared multiplier: tap or hidden value times the weight just read.
   assign mul_prod = opa_ff * wt_s;

   // Saturate the hidden pre-activation to [-8, 8) and take quarter steps for the table.
   always_comb begin
      if (acc_h_ff[HACC_W-1:31] == '0 || acc_h_ff[HACC_W-1:31] == '1) begin
         hid_sat = acc_h_ff[31:0];
      end else if (acc_h_ff[HACC_W-1]) begin
         hid_sat = mlpwp_pkg::SAT_MIN;
      end else begin
         hid_sat = mlpwp_pkg::SAT_MAX;
      end
   end

   assign sig_index = {~hid_sat[31], hid_sat[30:26]};
   assign sig_value = mlpwp_pkg::SIGMOID_TABLE[sig_index];

   // The network output saturates to the 32-bit Q2.30 range.
   always_comb begin
      if (acc_o_ff[OACC_W-1:31] == '0 || acc_o_ff[OACC_W-1:31] == '1) begin
         out_sat = acc_o_ff[31:0];
      end else if (acc_o_ff[OACC_W-1]) begin
         out_sat = mlpwp_pkg::SAT_MIN;
      end else begin
         out_sat = mlpwp_pkg::SAT_MAX;
      end
   end

   // Sequencer and the three-step datapath: weight read, multiply, accumulate.
   always_comb begin
      state_in     = state_ff;
      unit_in      = unit_ff;
      tap_in       = tap_ff;
      hw_ptr_in    = hw_ptr_ff;
      clr_ptr_in   = clr_ptr_ff;
      fill_in      = fill_ff;
      taps_in      = taps_ff;
      opa_in       = '0;
      op1_in       = mlpwp_pkg::OP_NONE;
      op2_in       = op1_ff;
      prod_in      = prod_ff;
      acc_h_in     = acc_h_ff;
      acc_o_in     = acc_o_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pred_in  = rsp_pred_ff;
      rsp_full_in  = rsp_full_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_ptr_ff;
      ram_wdata    = '0;
      ram_raddr    = hw_ptr_ff;

      // Multiply step: thresholds are scaled by a shift and enter negated.
      case (op1_ff)
         mlpwp_pkg::OP_HMAC, mlpwp_pkg::OP_OMAC: begin
            prod_in = mul_prod;
         end
         mlpwp_pkg::OP_HTHR: begin
            prod_in = -(33'(wt_s) <<< 14);
         end
         mlpwp_pkg::OP_OTHR: begin
            prod_in = -(33'(wt_s) <<< 16);
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase

      // Accumulate step.
      case (op2_ff)
         mlpwp_pkg::OP_HMAC, mlpwp_pkg::OP_HTHR: begin
            acc_h_in = acc_h_ff + HACC_W'(prod_ff);
         end
         mlpwp_pkg::OP_OMAC, mlpwp_pkg::OP_OTHR: begin
            acc_o_in = acc_o_ff + OACC_W'(prod_ff);
         end
         default: begin
            acc_h_in = acc_h_ff;
         end
      endcase

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mlpwp_pkg::ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_ptr_ff;
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == AW'(STORE_DEPTH - 1)) begin
               state_in = mlpwp_pkg::ST_IDLE;
            end
         end
         mlpwp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_kind == mlpwp_pkg::KIND_WRITE) begin
                  // Indexes past the end of the store are dropped.
                  if (32'(req_index) < STORE_DEPTH) begin
                     ram_we    = 1'b1;
                     ram_waddr = req_index[AW-1:0];
                     ram_wdata = req_weight;
                  end
               end else begin
                  for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
                     taps_in[i] = taps_ff[i + 1];
                  end
                  taps_in[WINDOW_TAPS-1] = req_sample;
                  if (fill_ff != CW'(WINDOW_TAPS)) begin
                     fill_in = fill_ff + CW'(1);
                  end
                  acc_h_in  = '0;
                  acc_o_in  = '0;
                  unit_in   = '0;
                  tap_in    = '0;
                  hw_ptr_in = '0;
                  state_in  = mlpwp_pkg::ST_HMAC;
               end
            end
         end
         mlpwp_pkg::ST_HMAC: begin
            if (tap_ff == CW'(WINDOW_TAPS)) begin
               ram_raddr = AW'(HT_BASE) + AW'(unit_ff);
               op1_in    = mlpwp_pkg::OP_HTHR;
               tap_in    = '0;
               state_in  = mlpwp_pkg::ST_HDRAIN;
            end else begin
               ram_raddr = hw_ptr_ff;
               op1_in    = mlpwp_pkg::OP_HMAC;
               opa_in    = 17'(taps_ff[tap_ff[TW-1:0]]);
               hw_ptr_in = hw_ptr_ff + AW'(1);
               tap_in    = tap_ff + CW'(1);
            end
         end
         mlpwp_pkg::ST_HDRAIN: begin
            // The threshold commits on the edge that ends the cycle its multiply stage empties.
            if (op1_ff == mlpwp_pkg::OP_NONE) begin
               state_in = mlpwp_pkg::ST_SIG;
            end
         end
         mlpwp_pkg::ST_SIG: begin
            ram_raddr = AW'(OW_BASE) + AW'(unit_ff);
            op1_in    = mlpwp_pkg::OP_OMAC;
            opa_in    = signed'({1'b0, sig_value});
            acc_h_in  = '0;
            if (unit_ff == UW'(HIDDEN_UNITS - 1)) begin
               state_in = mlpwp_pkg::ST_OTHR;
            end else begin
               unit_in  = unit_ff + UW'(1);
               state_in = mlpwp_pkg::ST_HMAC;
            end
         end
         mlpwp_pkg::ST_OTHR: begin
            ram_raddr = AW'(OT_INDEX);
            op1_in    = mlpwp_pkg::OP_OTHR;
            state_in  = mlpwp_pkg::ST_ODRAIN;
         end
         mlpwp_pkg::ST_ODRAIN: begin
            if (op1_ff == mlpwp_pkg::OP_NONE) begin
               state_in = mlpwp_pkg::ST_DONE;
            end
         end
         mlpwp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pred_in  = out_sat;
               rsp_full_in  = (fill_ff == CW'(WINDOW_TAPS));
               state_in     = mlpwp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlpwp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpwp_pkg::ST_CLEAR;
         op1_ff       <= mlpwp_pkg::OP_NONE;
         op2_ff       <= mlpwp_pkg::OP_NONE;
         unit_ff      <= '0;
         tap_ff       <= '0;
         hw_ptr_ff    <= '0;
         clr_ptr_ff   <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_TAPS; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         op1_ff       <= op1_in;
         op2_ff       <= op2_in;
         unit_ff      <= unit_in;
         tap_ff       <= tap_in;
         hw_ptr_ff    <= hw_ptr_in;
         clr_ptr_ff   <= clr_ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         taps_ff      <= taps_in;
      end
      opa_ff      <= opa_in;
      prod_ff     <= prod_in;
      acc_h_ff    <= acc_h_in;
      acc_o_ff    <= acc_o_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_full_ff <= rsp_full_in;
   end

endmodule

>>> hdl/mlpwp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mlpwp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 31
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
